// File: rtl/cev_pkg.sv
package cev_pkg;

	// queue geometry
	localparam int DEPTH = 512;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = AW + 1;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_PURGE  = 2'd2,
		OP_RDDROP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_APPENDED  = 3'd0,
		ST_COALESCED = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_POPPED    = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_PURGED    = 3'd5,
		ST_DROP_READ = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PURGE
	} state_t;

	// one queued operation
	typedef struct packed {
		op_t         op;
		logic [15:0] src;
		logic [7:0]  typ;
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] val;
	} item_t;

	// one stored event
	typedef struct packed {
		logic [15:0] src;
		logic [7:0]  typ;
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] val;
	} ent_t;

	// one result
	typedef struct packed {
		status_t     status;
		ent_t        ev;
		logic [PW-1:0] occ;
		logic [15:0] drop;
	} res_t;

endpackage

// File: rtl/coalescing_event_queue.sv
// Coalescing event queue: 512-entry ring of events with move coalescing.
// Push, pop and drop read pass through the two-entry front buffer, the operation
// register and the result register; one operation executes at a time. A purge
// walks the memory with the single read port, one entry a cycle.
// Reset clears pointers, drop count and move type; memory is not cleared.
module coalescing_event_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] source_id,
	input  logic [7:0]  event_type,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [31:0] event_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] out_source,
	output logic [7:0]  out_type,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [31:0] out_value,
	output logic [cev_pkg::PW-1:0] occupancy,
	output logic [15:0] drop_count
);
	import cev_pkg::*;

	logic [7:0] move_type_q;
	item_t      in_item, head;
	logic       head_valid, deq;
	res_t       res;

	// move type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			move_type_q <= '0;
		else if (cfg_wr_en)
			move_type_q <= cfg_wr_data;
	end

	assign in_item = '{op_t'(mode), source_id, event_type, pos_x, pos_y, event_value};

	cev_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.head_valid, .head, .deq
	);

	cev_back u_back (
		.clk, .arst_n, .move_type(move_type_q), .head_valid, .head, .deq,
		.res_valid(out_valid), .res, .out_stall
	);

	assign status     = res.status;
	assign out_source = res.ev.src;
	assign out_type   = res.ev.typ;
	assign out_x      = res.ev.x;
	assign out_y      = res.ev.y;
	assign out_value  = res.ev.val;
	assign occupancy  = res.occ;
	assign drop_count = res.drop;

endmodule

// File: rtl/cev_front.sv
module cev_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  cev_pkg::item_t in_item,
	output logic          head_valid,
	output cev_pkg::item_t head,
	input  logic          deq
);
	import cev_pkg::*;

	// two-entry queue between intake and execution
	item_t      buf_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       enq;

	assign in_stall   = cnt_q == 2'd2;
	assign enq        = in_valid && !in_stall;
	assign head_valid = cnt_q != 2'd0;
	assign head       = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
			if (deq)
				rd_q <= !rd_q;
		end
	end

	// write slot is the head when empty, else the one after the head
	always_ff @(posedge clk) begin
		if (enq)
			buf_q[rd_q ^ cnt_q[0]] <= in_item;
	end

endmodule

// File: rtl/cev_back.sv
module cev_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     move_type,
	input  logic           head_valid,
	input  cev_pkg::item_t head,
	output logic           deq,
	output logic           res_valid,
	output cev_pkg::res_t  res,
	input  logic           out_stall
);
	import cev_pkg::*;

	ent_t    mem [DEPTH];
	ent_t    rdata_s1;
	state_t  state_q, state_d;
	item_t   op_q;
	logic [PW-1:0] wp_q, rp_q, n_q, kept_q;
	logic [15:0]   drop_q;
	logic          res_v_q;
	res_t          res_q;

	logic [PW-1:0] count, kept_nx, wp_d, rp_d, n_d, kept_d;
	logic [AW-1:0] raddr, waddr;
	logic [15:0]   drop_d;
	logic          start, we, load, merge, keep, last;
	ent_t          wdata;
	res_t          res_d;

	assign count = wp_q - rp_q;
	assign start = state_q == S_IDLE && head_valid && (!res_v_q || !out_stall);
	assign deq   = start;
	assign merge = op_q.typ == move_type && count != '0 &&
		rdata_s1.typ == move_type && rdata_s1.src == op_q.src;
	assign keep    = rdata_s1.src != op_q.src;
	assign kept_nx = kept_q + {{(PW-1){1'b0}}, keep};
	assign last    = n_q + 1'b1 == count;

	// read address: newest entry for push, else walk from the oldest
	always_comb begin
		logic [PW-1:0] a;
		a = rp_q;
		if (state_q == S_IDLE && head.op == OP_PUSH)
			a = wp_q - 1'b1;
		else if (state_q == S_PURGE)
			a = rp_q + n_q + 1'b1;
		raddr = a[AW-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_EXEC;
			S_EXEC:  state_d = (op_q.op == OP_PURGE && count != '0) ? S_PURGE : S_IDLE;
			S_PURGE: if (last) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath actions
	always_comb begin
		logic [PW-1:0] a;
		a      = wp_q;
		we     = 1'b0;
		wdata  = '{op_q.src, op_q.typ, op_q.x, op_q.y, op_q.val};
		wp_d   = wp_q;
		rp_d   = rp_q;
		drop_d = drop_q;
		n_d    = n_q;
		kept_d = kept_q;
		load   = 1'b0;
		res_d  = '0;
		unique case (state_q)
			S_IDLE: ;
			S_EXEC: begin
				n_d    = '0;
				kept_d = '0;
				unique case (op_q.op)
					OP_PUSH: begin
						load = 1'b1;
						if (merge) begin
							we           = 1'b1;
							a            = wp_q - 1'b1;
							res_d.status = ST_COALESCED;
						end else if (count == PW'(DEPTH)) begin
							if (drop_q != '1)
								drop_d = drop_q + 1'b1;
							res_d.status = ST_DROPPED;
						end else begin
							we           = 1'b1;
							wp_d         = wp_q + 1'b1;
							res_d.status = ST_APPENDED;
						end
					end
					OP_POP: begin
						load = 1'b1;
						if (count == '0) begin
							res_d.status = ST_EMPTY;
						end else begin
							res_d.status = ST_POPPED;
							res_d.ev     = rdata_s1;
							rp_d         = rp_q + 1'b1;
						end
					end
					OP_PURGE: begin
						if (count == '0) begin
							load         = 1'b1;
							res_d.status = ST_PURGED;
						end
					end
					OP_RDDROP: begin
						load         = 1'b1;
						drop_d       = '0;
						res_d.status = ST_DROP_READ;
					end
					default: ;
				endcase
			end
			S_PURGE: begin
				// compact survivors toward the oldest slot
				wdata  = rdata_s1;
				a      = rp_q + kept_q;
				we     = keep && kept_q != n_q;
				kept_d = kept_nx;
				n_d    = n_q + 1'b1;
				if (last) begin
					wp_d         = rp_q + kept_nx;
					load         = 1'b1;
					res_d.status = ST_PURGED;
				end
			end
			default: ;
		endcase
		waddr      = a[AW-1:0];
		res_d.occ  = wp_d - rp_d;
		res_d.drop = (state_q == S_EXEC && op_q.op == OP_RDDROP) ? drop_q : drop_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			drop_q  <= '0;
			n_q     <= '0;
			kept_q  <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			drop_q  <= drop_d;
			n_q     <= n_d;
			kept_q  <= kept_d;
			if (load)
				res_v_q <= 1'b1;
			else if (!out_stall)
				res_v_q <= 1'b0;
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		if (start)
			op_q <= head;
		if (load)
			res_q <= res_d;
	end

	// event memory
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule

// File: rtl/cev_checker.sv
module cev_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [cev_pkg::PW-1:0] occupancy
);
	import cev_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(occupancy))
		else $error("stalled result changed");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= PW'(DEPTH))
		else $error("occupancy above depth");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0)
		else $error("empty pop with entries left");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DROPPED |-> occupancy == PW'(DEPTH))
		else $error("drop while not full");

endmodule

bind coalescing_event_queue cev_checker u_cev_checker (
	.clk, .arst_n, .out_valid, .out_stall, .status, .occupancy
);

// File: tb/tb.sv
module tb;
	import cev_pkg::*;

	localparam int QDEPTH = DEPTH;
	localparam int LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic [15:0] source_id = '0;
	logic [7:0] event_type = '0;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic signed [31:0] event_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [15:0] out_source;
	logic [7:0] out_type;
	logic signed [15:0] out_x, out_y;
	logic signed [31:0] out_value;
	logic [PW-1:0] occupancy;
	logic [15:0] drop_count;

	coalescing_event_queue dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .source_id(source_id), .event_type(event_type),
		.pos_x(pos_x), .pos_y(pos_y), .event_value(event_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_source(out_source), .out_type(out_type),
		.out_x(out_x), .out_y(out_y), .out_value(out_value),
		.occupancy(occupancy), .drop_count(drop_count)
	);

	always #4 clk = ~clk;

	// predictor state: event list oldest first
	ent_t queue_model[$];
	logic [15:0] drops_model;
	logic [7:0] move_type;
	res_t results_due[$];

	int errors = 0;
	int shown = 0;
	int cycles = 0;
	int stall_left = 0;
	bit quiet = 1'b0;      // no idling in the final part

	// compute the expected result of one operation and update the model
	function automatic res_t predict_event_op(op_t op, ent_t ev);
		res_t r;
		int kept;
		r = '0;
		case (op)
			OP_PUSH: begin
				if (ev.typ == move_type && queue_model.size() > 0 &&
						queue_model[$].typ == move_type && queue_model[$].src == ev.src) begin
					queue_model[$].x = ev.x;
					queue_model[$].y = ev.y;
					queue_model[$].val = ev.val;
					r.status = ST_COALESCED;
				end else if (queue_model.size() >= QDEPTH) begin
					if (drops_model != 16'hFFFF) drops_model++;
					r.status = ST_DROPPED;
				end else begin
					queue_model.push_back(ev);
					r.status = ST_APPENDED;
				end
				r.drop = drops_model;
			end
			OP_POP: begin
				if (queue_model.size() == 0) r.status = ST_EMPTY;
				else begin
					r.ev = queue_model.pop_front();
					r.status = ST_POPPED;
				end
				r.drop = drops_model;
			end
			OP_PURGE: begin
				kept = 0;
				for (int i = 0; i < queue_model.size(); i++)
					if (queue_model[i].src != ev.src) queue_model[kept++] = queue_model[i];
				while (queue_model.size() > kept) void'(queue_model.pop_back());
				r.status = ST_PURGED;
				r.drop = drops_model;
			end
			default: begin
				r.drop = drops_model;
				drops_model = '0;
				r.status = ST_DROP_READ;
			end
		endcase
		r.occ = PW'(queue_model.size());
		return r;
	endfunction

	// send one operation, at times with a random gap ahead of it unless quiet
	task automatic send_op(op_t op, ent_t ev);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		source_id <= ev.src;
		event_type <= ev.typ;
		pos_x <= ev.x;
		pos_y <= ev.y;
		event_value <= ev.val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		results_due.push_back(predict_event_op(op, ev));
	endtask

	function automatic ent_t rand_event(logic [15:0] src, logic [7:0] typ);
		ent_t e;
		e.src = src;
		e.typ = typ;
		e.x = 16'($urandom);
		e.y = 16'($urandom);
		e.val = $urandom;
		return e;
	endfunction

	// wait until all results are in, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_move_type(logic [7:0] t);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= t;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		move_type = t;
	endtask

	// random sink side stall bursts, off when quiet
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 16);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// check every result transfer against the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result status=%0d", status);
				end
			end else begin
				res_t want;
				want = results_due.pop_front();
				if (status !== want.status || out_source !== want.ev.src ||
						out_type !== want.ev.typ || out_x !== want.ev.x ||
						out_y !== want.ev.y || out_value !== want.ev.val ||
						occupancy !== want.occ || drop_count !== want.drop) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("mismatch exp st=%0d src=%h typ=%h x=%h y=%h v=%h occ=%0d drop=%0d",
							want.status, want.ev.src, want.ev.typ, want.ev.x, want.ev.y,
							want.ev.val, want.occ, want.drop);
						$display("         got st=%0d src=%h typ=%h x=%h y=%h v=%h occ=%0d drop=%0d",
							status, out_source, out_type, out_x, out_y, out_value,
							occupancy, drop_count);
					end
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// directed: extremes, empty pop, coalescing, purge, drop read
	task automatic test_directed();
		ent_t e;
		send_op(OP_POP, '0);
		send_op(OP_RDDROP, '1);
		e = '{16'hFFFF, 8'hFF, 16'h7FFF, 16'h8000, 32'h8000_0000};
		send_op(OP_PUSH, e);
		e = '{16'h0000, 8'h00, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF};
		send_op(OP_PUSH, e);
		send_op(OP_PUSH, rand_event(16'h0000, 8'h00));   // merges with move type 0
		send_op(OP_PUSH, rand_event(16'h0001, 8'h00));
		send_op(OP_PURGE, '{16'h0000, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF});
		send_op(OP_PURGE, rand_event(16'h1234, 8'h00));  // source not present
		send_op(OP_POP, '0);
		send_op(OP_POP, '0);
		send_op(OP_POP, '0);
		send_op(OP_PUSH, rand_event(16'h0005, 8'h00));   // move into empty queue
		send_op(OP_POP, '0);
	endtask

	// fill the queue, drop, coalesce into full queue, read drop count, purge and drain
	task automatic test_full_queue(logic [7:0] mt);
		write_move_type(mt);
		for (int i = 0; i < QDEPTH - 1; i++)
			send_op(OP_PUSH, rand_event(16'($urandom_range(0, 3)), mt ^ 8'h01));
		send_op(OP_PUSH, rand_event(16'h0007, mt));
		for (int i = 0; i < 6; i++)
			send_op(OP_PUSH, rand_event(16'h0009, $urandom_range(0, 1) ? mt : 8'hA5));
		send_op(OP_PUSH, rand_event(16'h0007, mt));      // merges while full
		send_op(OP_RDDROP, rand_event(16'($urandom), 8'($urandom)));
		send_op(OP_PURGE, rand_event(16'h0002, 8'h00));
		send_op(OP_PURGE, rand_event(16'h0001, 8'h00));
		while (queue_model.size() != 0)
			send_op(OP_POP, rand_event(16'($urandom), 8'($urandom)));
		send_op(OP_POP, '0);
	endtask

	// random mix, mostly move bursts from a few sources
	task automatic test_random(int count, logic [7:0] mt);
		int r;
		op_t op;
		ent_t e;
		write_move_type(mt);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50) op = OP_PUSH;
			else if (r < 85) op = OP_POP;
			else if (r < 93) op = OP_PURGE;
			else op = OP_RDDROP;
			e = rand_event($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)),
				$urandom_range(0, 2) != 0 ? mt : 8'($urandom));
			send_op(op, e);
		end
	endtask

	initial begin
		drops_model = '0;
		move_type = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_queue(8'hFF);
		test_random(300, 8'h00);
		test_random(300, 8'h5A);
		test_random(250, 8'hFF);
		drain_results();
		quiet = 1'b1;
		test_random(200, 8'h3C);
		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

// File: files.f
rtl/cev_pkg.sv
rtl/cev_front.sv
rtl/cev_back.sv
rtl/coalescing_event_queue.sv
rtl/cev_checker.sv
tb/tb.sv
